// ===== rtl/wpm_pkg.sv =====
// shared constants and types for the wildcard pattern matcher
`default_nettype none
package wpm_pkg;

  localparam int unsigned PATTERN_MAX_DEF = 32;
  localparam int unsigned SYM_W = 8;
  localparam int unsigned LEN_W = 6;

  localparam logic [SYM_W-1:0] SYM_STAR = 8'd42;
  localparam logic [SYM_W-1:0] SYM_ANY  = 8'd63;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_RESTART = 2'd2,
    OP_TEXT    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_HOLD    = 2'd0,
    MODE_TEXT    = 2'd1,
    MODE_REBUILD = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_t;

  // row-wide command seen by every cell
  typedef struct packed {
    mode_t            mode;
    logic [SYM_W-1:0] sym;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/wpm_if.sv =====
// item channels of the wildcard pattern matcher
`default_nettype none
interface wpm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] symbol;

  modport source (output valid, output op, output symbol, input ready);
  modport sink (input valid, input op, input symbol, output ready);
endinterface

interface wpm_out_if;
  logic       valid;
  logic       ready;
  logic       matched;
  logic       status;
  logic [5:0] pattern_length;

  modport source (output valid, output matched, output status, output pattern_length,
                  input ready);
  modport sink (input valid, input matched, input status, input pattern_length,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/wildcard_pattern_matcher.sv =====
// wildcard pattern matcher: glob match of streamed text against stored pattern
// result: in the output register in the cycle after its item is accepted
// throughput: one item per cycle unless the output stalls; every pattern cell
//   updates at once; the clock period is set by the star ripple across the row
// reset: pattern empty, text restarted, no result pending
`default_nettype none
module wildcard_pattern_matcher #(
  parameter int unsigned PATTERN_MAX = wpm_pkg::PATTERN_MAX_DEF
) (
  input  wire              clk,
  input  wire              rst,
  wpm_in_if.sink           item_in,
  wpm_out_if.source        result_out
);

  localparam int unsigned CNT_W = $clog2(PATTERN_MAX + 1);
  localparam int unsigned EXT_W = CNT_W + wpm_pkg::LEN_W;

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic                row0;
  logic                row0_next;
  logic                full;
  logic                accept;
  logic                append_ok;
  logic                status_next;
  logic                matched_next;
  wpm_pkg::cell_ctrl_t ctrl;
  logic [PATTERN_MAX-1:0] row_q;
  logic [PATTERN_MAX-1:0] row_next;
  logic [PATTERN_MAX:0]   live_next;
  logic [PATTERN_MAX-1:0] last_hit;
  logic [EXT_W-1:0]       len_ext;

  logic                       out_valid;
  logic                       out_matched;
  logic                       out_status;
  logic [wpm_pkg::LEN_W-1:0]  out_len;

  assign item_in.ready = ~out_valid | result_out.ready;
  assign accept        = item_in.valid & item_in.ready;
  assign full          = (count == CNT_W'(PATTERN_MAX));

  always_comb begin
    ctrl.sym    = item_in.symbol;
    ctrl.mode   = wpm_pkg::MODE_HOLD;
    append_ok   = 1'b0;
    status_next = 1'b0;
    count_next  = count;
    row0_next   = row0;
    if (accept) begin
      case (wpm_pkg::op_t'(item_in.op))
        wpm_pkg::OP_CLEAR: begin
          ctrl.mode  = wpm_pkg::MODE_CLEAR;
          count_next = '0;
          row0_next  = 1'b1;
        end
        wpm_pkg::OP_APPEND: begin
          if (full) begin
            status_next = 1'b1;
          end else begin
            append_ok  = 1'b1;
            ctrl.mode  = wpm_pkg::MODE_REBUILD;
            count_next = count + 1'b1;
            row0_next  = 1'b1;
          end
        end
        wpm_pkg::OP_RESTART: begin
          ctrl.mode = wpm_pkg::MODE_REBUILD;
          row0_next = 1'b1;
        end
        wpm_pkg::OP_TEXT: begin
          ctrl.mode = wpm_pkg::MODE_TEXT;
          row0_next = 1'b0;
        end
        default: ctrl.mode = wpm_pkg::MODE_HOLD;
      endcase
    end
  end

  assign live_next[PATTERN_MAX] = 1'b0;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    logic left_bit;
    logic left_bit_next;
    if (i == 0) begin : g_first
      assign left_bit      = row0;
      assign left_bit_next = row0_next;
    end else begin : g_rest
      assign left_bit      = row_q[i-1];
      assign left_bit_next = row_next[i-1];
    end

    wpm_cell u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctrl          (ctrl),
      .wr            (append_ok && (count == CNT_W'(i))),
      .left_bit      (left_bit),
      .left_bit_next (left_bit_next),
      .bit_q         (row_q[i]),
      .bit_next      (row_next[i]),
      .live_next     (live_next[i])
    );

    // only the last live cell speaks for the whole pattern
    assign last_hit[i] = row_next[i] & live_next[i] & ~live_next[i+1];
  end

  assign matched_next = (row0_next & ~live_next[0]) | (|last_hit);
  assign len_ext      = {{wpm_pkg::LEN_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      row0      <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      row0  <= row0_next;
      if (accept) out_valid <= 1'b1;
      else if (result_out.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_matched <= matched_next;
      out_status  <= status_next;
      out_len     <= len_ext[wpm_pkg::LEN_W-1:0];
    end
  end

  assign result_out.valid          = out_valid;
  assign result_out.matched        = out_matched;
  assign result_out.status         = out_status;
  assign result_out.pattern_length = out_len;

endmodule
`default_nettype wire

// ===== rtl/wpm_cell.sv =====
// one pattern position: stored byte, live flag and its match bit
`default_nettype none
module wpm_cell (
  input  wire                  clk,
  input  wire                  rst,
  input  wire wpm_pkg::cell_ctrl_t ctrl,
  input  wire                  wr,
  input  wire                  left_bit,
  input  wire                  left_bit_next,
  output logic                 bit_q,
  output logic                 bit_next,
  output logic                 live_next
);

  logic [wpm_pkg::SYM_W-1:0] pat;
  logic                      star;
  logic                      live;
  logic [wpm_pkg::SYM_W-1:0] eff_pat;
  logic                      eff_star;
  logic                      eff_live;
  logic                      hit;

  assign eff_pat  = wr ? ctrl.sym : pat;
  assign eff_star = wr ? (ctrl.sym == wpm_pkg::SYM_STAR) : star;
  assign eff_live = live | wr;
  assign hit      = (eff_pat == wpm_pkg::SYM_ANY) || (eff_pat == ctrl.sym);

  always_comb begin
    live_next = eff_live;
    case (ctrl.mode)
      wpm_pkg::MODE_TEXT: begin
        // star ripples the freshly computed left bit along the row
        if (!eff_live) bit_next = 1'b0;
        else if (eff_star) bit_next = bit_q | left_bit_next;
        else bit_next = hit & left_bit;
      end
      wpm_pkg::MODE_REBUILD: bit_next = eff_live & eff_star & left_bit_next;
      wpm_pkg::MODE_CLEAR: begin
        bit_next  = 1'b0;
        live_next = 1'b0;
      end
      default: bit_next = bit_q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_q <= 1'b0;
      live  <= 1'b0;
    end else begin
      bit_q <= bit_next;
      live  <= live_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      pat  <= ctrl.sym;
      star <= (ctrl.sym == wpm_pkg::SYM_STAR);
    end
  end

endmodule
`default_nettype wire

// ===== dv/wildcard_pattern_matcher_test.sv =====
// testbench for the wildcard pattern matcher: directed table, random glob sequences, scoreboard
`timescale 1ns / 1ps
module wildcard_pattern_matcher_test;
  import wpm_pkg::*;

  localparam int PAT_MAX = PATTERN_MAX_DEF;
  localparam logic [SYM_W-1:0] CH_A = 8'h61;

  typedef struct packed {
    logic             matched;
    logic             status;
    logic [LEN_W-1:0] plen;
  } glob_result_t;

  typedef struct {
    op_t              op;
    logic [SYM_W-1:0] sym;
    int               reps;
    bit               pinned;
    glob_result_t     want;
  } table_row_t;

  logic clk;
  logic rst;

  wpm_in_if  in_if ();
  wpm_out_if out_if ();

  wildcard_pattern_matcher u_dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (in_if),
    .result_out (out_if)
  );

  // shadow copy of the matcher state
  logic [SYM_W-1:0] glob_pattern [PAT_MAX];
  int unsigned      glob_len;
  logic [PAT_MAX:0] glob_row;

  glob_result_t pending_results [$];
  table_row_t   directed_rows [$];

  int  send_idle_pct;
  int  recv_idle_pct;
  int  items_sent;
  int  results_checked;
  int  matches_seen;
  int  full_flags_seen;
  int  errors;
  bit           pin_expect;
  glob_result_t pinned_result;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3ms;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_mismatch(string msg);
    errors++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  function automatic void rebuild_glob_row();
    glob_row = '0;
    glob_row[0] = 1'b1;
    for (int j = 1; j <= glob_len; j++) begin
      glob_row[j] = glob_row[j-1] && (glob_pattern[j-1] == SYM_STAR);
    end
  endfunction

  // one text byte through the row of match bits
  function automatic void scan_glob_text(logic [SYM_W-1:0] c);
    logic diag;
    logic above;
    diag = glob_row[0];
    glob_row[0] = 1'b0;
    for (int j = 1; j <= glob_len; j++) begin
      above = glob_row[j];
      if (glob_pattern[j-1] == SYM_STAR) begin
        glob_row[j] = above || glob_row[j-1];
      end else begin
        glob_row[j] = ((glob_pattern[j-1] == SYM_ANY) || (glob_pattern[j-1] == c)) && diag;
      end
      diag = above;
    end
  endfunction

  function automatic glob_result_t glob_step(op_t op, logic [SYM_W-1:0] sym);
    glob_result_t res;
    res = '0;
    case (op)
      OP_CLEAR: begin
        glob_len = 0;
        rebuild_glob_row();
      end
      OP_APPEND: begin
        if (glob_len >= PAT_MAX) begin
          res.status = 1'b1;
        end else begin
          glob_pattern[glob_len] = sym;
          glob_len++;
          rebuild_glob_row();
        end
      end
      OP_RESTART: rebuild_glob_row();
      default: scan_glob_text(sym);
    endcase
    res.matched = glob_row[glob_len];
    res.plen = glob_len[LEN_W-1:0];
    return res;
  endfunction

  // scoreboard: results are checked before the same edge's input is predicted
  always @(posedge clk) begin : scoreboard
    glob_result_t got;
    glob_result_t want;
    glob_result_t calc;
    if (!rst) begin
      if (out_if.valid && out_if.ready) begin
        got.matched = out_if.matched;
        got.status = out_if.status;
        got.plen = out_if.pattern_length;
        if (pending_results.size() == 0) begin
          report_mismatch("result with no item waiting for it");
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (got.matched) matches_seen++;
          if (got.status) full_flags_seen++;
          if (got.matched !== want.matched)
            report_mismatch($sformatf("matched %b, want %b", got.matched, want.matched));
          if (got.status !== want.status)
            report_mismatch($sformatf("status %b, want %b", got.status, want.status));
          if (got.plen !== want.plen)
            report_mismatch($sformatf("pattern_length %0d, want %0d", got.plen, want.plen));
        end
      end
      if (in_if.valid && in_if.ready) begin
        calc = glob_step(op_t'(in_if.op), in_if.symbol);
        pending_results.push_back(pin_expect ? pinned_result : calc);
      end
    end
  end

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic send_item(op_t op, logic [SYM_W-1:0] sym, bit pin, glob_result_t want);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.op <= op;
    in_if.symbol <= sym;
    pin_expect = pin;
    pinned_result = want;
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [SYM_W-1:0] pick_letter();
    if ($urandom_range(0, 3) == 0) return SYM_W'($urandom_range(0, 255));
    return CH_A + SYM_W'($urandom_range(0, 1));
  endfunction

  task automatic add_row(op_t op, logic [SYM_W-1:0] sym, int reps, int pinned,
                         int m, int s, int l);
    table_row_t row;
    row.op = op;
    row.sym = sym;
    row.reps = reps;
    row.pinned = pinned[0];
    row.want = '{matched: m[0], status: s[0], plen: LEN_W'(l)};
    directed_rows.push_back(row);
  endtask

  // clear, build a pattern, then a few text runs (half of them built to match)
  task automatic run_glob_sequence();
    logic [SYM_W-1:0] pat_q [$];
    logic [SYM_W-1:0] txt_q [$];
    logic [SYM_W-1:0] b;
    int r;
    int plen;
    r = $urandom_range(0, 99);
    plen = (r < 80) ? $urandom_range(0, 6) : (r < 95) ? $urandom_range(7, 20)
                                                       : $urandom_range(30, 34);
    send_item(OP_CLEAR, SYM_W'($urandom_range(0, 255)), 1'b0, '0);
    repeat (plen) begin
      r = $urandom_range(0, 9);
      b = (r < 3) ? SYM_STAR : (r < 5) ? SYM_ANY : (r < 9) ? CH_A + SYM_W'($urandom_range(0, 1))
                                                           : SYM_W'($urandom_range(0, 255));
      pat_q.push_back(b);
      send_item(OP_APPEND, b, 1'b0, '0);
    end
    repeat ($urandom_range(1, 3)) begin
      send_item(OP_RESTART, SYM_W'($urandom_range(0, 255)), 1'b0, '0);
      txt_q.delete();
      if ($urandom_range(0, 1)) begin
        foreach (pat_q[i]) begin
          if (pat_q[i] == SYM_STAR) begin
            repeat ($urandom_range(0, 3)) txt_q.push_back(pick_letter());
          end else if (pat_q[i] == SYM_ANY) begin
            txt_q.push_back(SYM_W'($urandom_range(0, 255)));
          end else begin
            txt_q.push_back(pat_q[i]);
          end
        end
        // spoil a quarter of the matching texts
        if (txt_q.size() > 0 && $urandom_range(0, 3) == 0)
          txt_q[$urandom_range(0, txt_q.size() - 1)] = pick_letter();
      end else begin
        repeat ($urandom_range(0, 10)) txt_q.push_back(pick_letter());
      end
      foreach (txt_q[i]) send_item(OP_TEXT, txt_q[i], 1'b0, '0);
    end
  endtask

  task automatic run_phase(int s_idle, int r_idle, int quota, bit drain_once);
    int stop_at;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 8))
          send_item(op_t'($urandom_range(0, 3)), SYM_W'($urandom_range(0, 255)), 1'b0, '0);
      end else begin
        run_glob_sequence();
      end
      if (drain_once && items_sent > stop_at - quota / 2) begin
        hold_until_drained();
        drain_once = 1'b0;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_if.valid = 1'b0;
    in_if.op = OP_CLEAR;
    in_if.symbol = '0;
    out_if.ready = 1'b0;
    send_idle_pct = 7;
    recv_idle_pct = 52;
    items_sent = 0;
    results_checked = 0;
    matches_seen = 0;
    full_flags_seen = 0;
    errors = 0;
    pin_expect = 1'b0;
    pinned_result = '0;
    foreach (glob_pattern[i]) glob_pattern[i] = '0;
    glob_len = 0;
    rebuild_glob_row();

    add_row(OP_TEXT,    CH_A,     1,  1, 0, 0, 0);  // empty pattern never matches text
    add_row(OP_RESTART, 8'h00,    1,  1, 1, 0, 0);
    add_row(OP_APPEND,  SYM_STAR, 1,  1, 1, 0, 1);
    add_row(OP_TEXT,    8'h00,    1,  1, 1, 0, 1);
    add_row(OP_TEXT,    8'hff,    1,  1, 1, 0, 1);
    add_row(OP_APPEND,  SYM_ANY,  1,  1, 0, 0, 2);
    add_row(OP_TEXT,    8'hff,    1,  0, 0, 0, 0);
    add_row(OP_TEXT,    8'h78,    1,  0, 0, 0, 0);
    add_row(OP_APPEND,  CH_A,     1,  1, 0, 0, 3);
    add_row(OP_TEXT,    CH_A + 8'd1, 1, 0, 0, 0, 0);
    add_row(OP_TEXT,    CH_A,     1,  0, 0, 0, 0);
    add_row(OP_RESTART, 8'h55,    1,  0, 0, 0, 0);
    add_row(OP_CLEAR,   8'hff,    1,  1, 1, 0, 0);
    add_row(OP_APPEND,  SYM_ANY,  32, 0, 0, 0, 0);
    add_row(OP_APPEND,  CH_A,     1,  1, 0, 1, 32); // full pattern, append dropped
    add_row(OP_TEXT,    8'h5a,    32, 0, 0, 0, 0);
    add_row(OP_TEXT,    8'h00,    1,  0, 0, 0, 0);
    add_row(OP_CLEAR,   8'haa,    1,  1, 1, 0, 0);
    add_row(OP_APPEND,  SYM_STAR, 32, 0, 0, 0, 0);
    add_row(OP_APPEND,  8'hff,    1,  1, 1, 1, 32);
    add_row(OP_CLEAR,   8'h00,    1,  1, 1, 0, 0);
    add_row(OP_APPEND,  8'h00,    1,  1, 0, 0, 1);
    add_row(OP_APPEND,  8'hff,    1,  1, 0, 0, 2);
    add_row(OP_TEXT,    8'h00,    1,  0, 0, 0, 0);
    add_row(OP_TEXT,    8'hff,    1,  0, 0, 0, 0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      repeat (directed_rows[i].reps)
        send_item(directed_rows[i].op, directed_rows[i].sym, directed_rows[i].pinned,
                  directed_rows[i].want);
    end

    run_phase(7, 52, 425, 1'b0);
    run_phase(52, 7, 425, 1'b1);
    run_phase(0, 0, 425, 1'b0);

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("sent %0d items, checked %0d results", items_sent, results_checked);
    $display("saw %0d matches and %0d appends to a full pattern", matches_seen,
             full_flags_seen);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/wpm_pkg.sv
rtl/wpm_if.sv
rtl/wpm_cell.sv
rtl/wildcard_pattern_matcher.sv
dv/wildcard_pattern_matcher_test.sv
